### sv/ini_line_parser_unit_assert.svh
// Assertion macros for the INI line parser unit checker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef INI_LINE_PARSER_UNIT_ASSERT_SVH
`define INI_LINE_PARSER_UNIT_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define ILP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ILP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/ilp_pkg.sv
// Shared types, codes and helpers for the INI line parser unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ilp_pkg;

  localparam int SectionCharsDef = 64;
  localparam int KeyCharsDef     = 64;
  localparam int ValueCharsDef   = 256;

  // Width used for length compares and length output masking
  localparam int LenCmpW = 9;

  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_END  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] SEL_SECTION = 2'd0;
  localparam logic [1:0] SEL_KEY     = 2'd1;
  localparam logic [1:0] SEL_VALUE   = 2'd2;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_PAIR  = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;
  localparam logic [1:0] EV_DONE  = 2'd3;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_in;
    logic [1:0] store_select;
    logic [7:0] read_index;
  } ilp_in_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] read_byte;
    logic [6:0] section_length;
    logic [6:0] key_length;
    logic [8:0] value_length;
  } ilp_out_t;

  // Per-item control from the parser to the stores and the pipeline
  typedef struct packed {
    logic [1:0] event_res;
    logic       sec_we;
    logic       key_we;
    logic       val_we;
    logic [7:0] text_byte;  // blanks folded to space
    logic [7:0] raw_byte;
    logic       rd_sec;
    logic       rd_key;
    logic       rd_val;
  } ilp_ctl_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
  endfunction

endpackage

`default_nettype wire

### sv/ilp_store.sv
// Byte store with one write port and one registered read port.
// Used for the section, key and value text; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ilp_store #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/ilp_parser.sv
// Line classifier and length tracking for the INI line parser unit.
// Depends on ilp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilp_parser #(
  parameter int SectionChars = ilp_pkg::SectionCharsDef,
  parameter int KeyChars     = ilp_pkg::KeyCharsDef,
  parameter int ValueChars   = ilp_pkg::ValueCharsDef,
  parameter int SecAw        = 6,
  parameter int KeyAw        = 6,
  parameter int ValAw        = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire ilp_pkg::ilp_in_t item_i,
  output ilp_pkg::ilp_ctl_t     ctl_o,
  output logic [SecAw-1:0]      sec_waddr_o,
  output logic [KeyAw-1:0]      key_waddr_o,
  output logic [ValAw-1:0]      val_waddr_o,
  output logic [6:0]            section_length_o,
  output logic [6:0]            key_length_o,
  output logic [8:0]            value_length_o
);

  localparam int ScW = $clog2(SectionChars + 1);
  localparam int KcW = $clog2(KeyChars + 1);
  localparam int VcW = $clog2(ValueChars + 1);

  localparam logic [ScW-1:0] SecMax = ScW'(SectionChars);
  localparam logic [KcW-1:0] KeyMax = KcW'(KeyChars);
  localparam logic [VcW-1:0] ValMax = VcW'(ValueChars);

  typedef enum logic [9:0] {
    MODE_LINE       = 10'b00_0000_0001,
    MODE_SKIPLINE   = 10'b00_0000_0010,
    MODE_SEC_LEAD   = 10'b00_0000_0100,
    MODE_SEC        = 10'b00_0000_1000,
    MODE_KEY        = 10'b00_0001_0000,
    MODE_VAL_LEAD   = 10'b00_0010_0000,
    MODE_VAL        = 10'b00_0100_0000,
    MODE_AFTER_PAIR = 10'b00_1000_0000,
    MODE_ERROR      = 10'b01_0000_0000,
    MODE_DONE       = 10'b10_0000_0000
  } mode_e;

  mode_e          mode_q, mode_d, mode_v;
  logic [ScW-1:0] sc_q, sc_d;
  logic [KcW-1:0] kc_q, kc_d, kt_q, kt_d;
  logic [VcW-1:0] vc_q, vc_d, vt_q, vt_d;
  logic           sec_put, key_put, val_put;
  logic [7:0]     b;
  logic           blank;

  assign b     = item_i.byte_in;
  assign blank = ilp_pkg::is_blank(b);

  always_comb begin
    mode_d  = mode_q;
    mode_v  = mode_q;
    sc_d    = sc_q;
    kc_d    = kc_q;
    kt_d    = kt_q;
    vc_d    = vc_q;
    vt_d    = vt_q;
    sec_put = 1'b0;
    key_put = 1'b0;
    val_put = 1'b0;
    ctl_o   = '0;
    ctl_o.event_res = ilp_pkg::EV_NONE;
    ctl_o.text_byte = blank ? ilp_pkg::CH_SPACE : b;
    ctl_o.raw_byte  = b;
    sec_waddr_o = sc_q[SecAw-1:0];
    key_waddr_o = kc_q[KeyAw-1:0];
    val_waddr_o = vc_q[ValAw-1:0];

    unique case (item_i.func)
      ilp_pkg::FUNC_PUSH: begin
        if (mode_q != MODE_ERROR && mode_q != MODE_DONE) begin
          if (mode_q == MODE_AFTER_PAIR) begin
            kc_d   = '0;
            kt_d   = '0;
            vc_d   = '0;
            vt_d   = '0;
            mode_v = MODE_LINE;
          end
          unique case (mode_v)
            MODE_LINE: begin
              if (blank || b == ilp_pkg::CH_LF) begin
                mode_d = MODE_LINE;
              end else if (b == ilp_pkg::CH_HASH || b == ilp_pkg::CH_SEMI) begin
                mode_d = MODE_SKIPLINE;
              end else if (b == ilp_pkg::CH_LBRK) begin
                kc_d   = '0;
                kt_d   = '0;
                vc_d   = '0;
                vt_d   = '0;
                sc_d   = '0;
                mode_d = MODE_SEC_LEAD;
              end else if (b == ilp_pkg::CH_EQ) begin
                mode_d          = MODE_ERROR;
                ctl_o.event_res = ilp_pkg::EV_ERROR;
              end else begin
                kc_d    = '0;
                kt_d    = '0;
                mode_d  = MODE_KEY;
                key_put = 1'b1;
              end
            end
            MODE_SKIPLINE: begin
              mode_d = (b == ilp_pkg::CH_LF) ? MODE_LINE : MODE_SKIPLINE;
            end
            MODE_SEC_LEAD, MODE_SEC: begin
              if (b == ilp_pkg::CH_LF) begin
                mode_d = MODE_LINE;
              end else if (b == ilp_pkg::CH_RBRK) begin
                mode_d = MODE_SKIPLINE;
              end else if (mode_v == MODE_SEC_LEAD && blank) begin
                mode_d = MODE_SEC_LEAD;
              end else begin
                mode_d  = MODE_SEC;
                sec_put = 1'b1;
              end
            end
            MODE_KEY: begin
              if (b == ilp_pkg::CH_LF) begin
                mode_d          = MODE_ERROR;
                ctl_o.event_res = ilp_pkg::EV_ERROR;
              end else if (b == ilp_pkg::CH_EQ) begin
                if (kt_q == '0) begin
                  mode_d          = MODE_ERROR;
                  ctl_o.event_res = ilp_pkg::EV_ERROR;
                end else begin
                  mode_d = MODE_VAL_LEAD;
                end
              end else begin
                key_put = 1'b1;
              end
            end
            MODE_VAL_LEAD, MODE_VAL: begin
              if (b == ilp_pkg::CH_LF) begin
                mode_d          = MODE_AFTER_PAIR;
                ctl_o.event_res = ilp_pkg::EV_PAIR;
              end else if (mode_v == MODE_VAL_LEAD && blank) begin
                mode_d = MODE_VAL_LEAD;
              end else begin
                mode_d  = MODE_VAL;
                val_put = 1'b1;
              end
            end
            default: begin
              mode_d = mode_v;
            end
          endcase
        end
      end
      ilp_pkg::FUNC_END: begin
        unique case (mode_q)
          MODE_ERROR: begin
            ctl_o.event_res = ilp_pkg::EV_ERROR;
          end
          MODE_DONE: begin
            ctl_o.event_res = ilp_pkg::EV_DONE;
          end
          MODE_VAL: begin
            // value closed by end of input keeps its trailing blanks
            vt_d            = vc_q;
            mode_d          = MODE_DONE;
            ctl_o.event_res = ilp_pkg::EV_PAIR;
          end
          MODE_AFTER_PAIR: begin
            kc_d            = '0;
            kt_d            = '0;
            vc_d            = '0;
            vt_d            = '0;
            mode_d          = MODE_DONE;
            ctl_o.event_res = ilp_pkg::EV_DONE;
          end
          default: begin
            mode_d          = MODE_DONE;
            ctl_o.event_res = ilp_pkg::EV_DONE;
          end
        endcase
      end
      ilp_pkg::FUNC_READ: begin
        // index must fall within the reported length
        ctl_o.rd_sec = (item_i.store_select == ilp_pkg::SEL_SECTION) &&
                       ({1'b0, item_i.read_index} < ilp_pkg::LenCmpW'(sc_q));
        ctl_o.rd_key = (item_i.store_select == ilp_pkg::SEL_KEY) &&
                       ({1'b0, item_i.read_index} < ilp_pkg::LenCmpW'(kt_q));
        ctl_o.rd_val = (item_i.store_select == ilp_pkg::SEL_VALUE) &&
                       ({1'b0, item_i.read_index} < ilp_pkg::LenCmpW'(vt_q));
      end
      default: begin
        ctl_o.event_res = ilp_pkg::EV_NONE;
      end
    endcase

    // at most one store append per byte; bytes past capacity are dropped
    if (sec_put && sc_d < SecMax) begin
      ctl_o.sec_we = 1'b1;
      sec_waddr_o  = sc_d[SecAw-1:0];
      sc_d         = sc_d + ScW'(1);
    end
    if (key_put && kc_d < KeyMax) begin
      ctl_o.key_we = 1'b1;
      key_waddr_o  = kc_d[KeyAw-1:0];
      kc_d         = kc_d + KcW'(1);
      if (!blank) begin
        kt_d = kc_d;
      end
    end
    if (val_put && vc_d < ValMax) begin
      ctl_o.val_we = 1'b1;
      val_waddr_o  = vc_d[ValAw-1:0];
      vc_d         = vc_d + VcW'(1);
      if (!blank) begin
        vt_d = vc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINE;
      sc_q   <= '0;
      kc_q   <= '0;
      kt_q   <= '0;
      vc_q   <= '0;
      vt_q   <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      sc_q   <= sc_d;
      kc_q   <= kc_d;
      kt_q   <= kt_d;
      vc_q   <= vc_d;
      vt_q   <= vt_d;
    end
  end

  // lengths reported after this item's update, masked to the field widths
  logic [ilp_pkg::LenCmpW-1:0] sc_ext, kt_ext, vt_ext;

  assign sc_ext           = ilp_pkg::LenCmpW'(sc_d);
  assign kt_ext           = ilp_pkg::LenCmpW'(kt_d);
  assign vt_ext           = ilp_pkg::LenCmpW'(vt_d);
  assign section_length_o = sc_ext[6:0];
  assign key_length_o     = kt_ext[6:0];
  assign value_length_o   = vt_ext[8:0];

endmodule

`default_nettype wire

### sv/ini_line_parser_unit.sv
// INI line parser unit: one text byte, end mark or store read per transfer.
// Each item passes the parse stage register, then the output register, to its result.
// Throughput: one item per cycle unless stalled; the output reg decouples a stalled result.
// Reset clears the line mode, all lengths and the pipeline valids; the text stores
// are not cleared and are only read within the reported lengths.
// Depends on ilp_pkg, ilp_parser and ilp_store.
`timescale 1ns / 1ps
`default_nettype none

module ini_line_parser_unit #(
  parameter int SectionChars = ilp_pkg::SectionCharsDef,
  parameter int KeyChars     = ilp_pkg::KeyCharsDef,
  parameter int ValueChars   = ilp_pkg::ValueCharsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ilp_pkg::ilp_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ilp_pkg::ilp_out_t      out_data_o
);

  localparam int SecAw = (SectionChars > 1) ? $clog2(SectionChars) : 1;
  localparam int KeyAw = (KeyChars > 1) ? $clog2(KeyChars) : 1;
  localparam int ValAw = (ValueChars > 1) ? $clog2(ValueChars) : 1;

  logic              accept;
  ilp_pkg::ilp_ctl_t ctl;
  logic [SecAw-1:0]  sec_waddr;
  logic [KeyAw-1:0]  key_waddr;
  logic [ValAw-1:0]  val_waddr;
  logic [6:0]        sec_len, key_len;
  logic [8:0]        val_len;
  logic [7:0]        sec_rdata, key_rdata, val_rdata;

  // parse stage register
  logic       s1_valid_q;
  logic [1:0] s1_event_q;
  logic       s1_rd_sec_q, s1_rd_key_q, s1_rd_val_q;
  logic [6:0] s1_sec_len_q, s1_key_len_q;
  logic [8:0] s1_val_len_q;
  logic       s1_move;

  // output register
  logic              out_valid_q;
  ilp_pkg::ilp_out_t out_q, out_d;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  ilp_parser #(
    .SectionChars(SectionChars),
    .KeyChars    (KeyChars),
    .ValueChars  (ValueChars),
    .SecAw       (SecAw),
    .KeyAw       (KeyAw),
    .ValAw       (ValAw)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .item_i          (in_data_i),
    .ctl_o           (ctl),
    .sec_waddr_o     (sec_waddr),
    .key_waddr_o     (key_waddr),
    .val_waddr_o     (val_waddr),
    .section_length_o(sec_len),
    .key_length_o    (key_len),
    .value_length_o  (val_len)
  );

  ilp_store #(.Depth(SectionChars), .AddrW(SecAw)) u_sec_store (
    .clk_i  (clk_i),
    .we_i   (accept && ctl.sec_we),
    .waddr_i(sec_waddr),
    .wdata_i(ctl.text_byte),
    .re_i   (accept && ctl.rd_sec),
    .raddr_i(in_data_i.read_index[SecAw-1:0]),
    .rdata_o(sec_rdata)
  );

  ilp_store #(.Depth(KeyChars), .AddrW(KeyAw)) u_key_store (
    .clk_i  (clk_i),
    .we_i   (accept && ctl.key_we),
    .waddr_i(key_waddr),
    .wdata_i(ctl.text_byte),
    .re_i   (accept && ctl.rd_key),
    .raddr_i(in_data_i.read_index[KeyAw-1:0]),
    .rdata_o(key_rdata)
  );

  ilp_store #(.Depth(ValueChars), .AddrW(ValAw)) u_val_store (
    .clk_i  (clk_i),
    .we_i   (accept && ctl.val_we),
    .waddr_i(val_waddr),
    .wdata_i(ctl.raw_byte),
    .re_i   (accept && ctl.rd_val),
    .raddr_i(in_data_i.read_index[ValAw-1:0]),
    .rdata_o(val_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_event_q   <= ctl.event_res;
      s1_rd_sec_q  <= ctl.rd_sec;
      s1_rd_key_q  <= ctl.rd_key;
      s1_rd_val_q  <= ctl.rd_val;
      s1_sec_len_q <= sec_len;
      s1_key_len_q <= key_len;
      s1_val_len_q <= val_len;
    end
  end

  always_comb begin
    out_d                = '0;
    out_d.event_res      = s1_event_q;
    out_d.section_length = s1_sec_len_q;
    out_d.key_length     = s1_key_len_q;
    out_d.value_length   = s1_val_len_q;
    if (s1_rd_sec_q) begin
      out_d.read_byte = sec_rdata;
    end else if (s1_rd_key_q) begin
      out_d.read_byte = key_rdata;
    end else if (s1_rd_val_q) begin
      out_d.read_byte = val_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### sv/ilp_checker.sv
// Port-level checker for the INI line parser unit, bound to the top level.
// Depends on ilp_pkg and ini_line_parser_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ini_line_parser_unit_assert.svh"

module ilp_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire ilp_pkg::ilp_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire ilp_pkg::ilp_out_t out_data_o
);

  logic out_xfer;
  logic done_seen_q, err_seen_q;
  logic in_unused;

  assign out_xfer  = out_valid_o && out_ready_i;
  assign in_unused = in_valid_i ^ (^in_data_i);

  // error and finished states are terminal until reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
      err_seen_q  <= 1'b0;
    end else if (out_xfer && !in_unused && !(in_unused === 1'bx)) begin
      done_seen_q <= done_seen_q || (out_data_o.event_res == ilp_pkg::EV_DONE);
      err_seen_q  <= err_seen_q || (out_data_o.event_res == ilp_pkg::EV_ERROR);
    end else if (out_xfer) begin
      done_seen_q <= done_seen_q || (out_data_o.event_res == ilp_pkg::EV_DONE);
      err_seen_q  <= err_seen_q || (out_data_o.event_res == ilp_pkg::EV_ERROR);
    end
  end

  `ILP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o), "stalled result changed")

  `ILP_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o,
              "input stalled with empty output register")

  `ILP_ASSERT(a_value_len_cap, out_valid_o |-> out_data_o.value_length <= 9'd256,
              "value length beyond store capacity")

  `ILP_ASSERT(a_done_terminal,
              out_valid_o && done_seen_q |-> out_data_o.event_res != ilp_pkg::EV_ERROR,
              "parse error reported after finish")

  `ILP_ASSERT(a_error_sticky,
              out_valid_o && err_seen_q |->
                out_data_o.event_res != ilp_pkg::EV_PAIR &&
                out_data_o.event_res != ilp_pkg::EV_DONE,
              "pair or finish reported after parse error")

endmodule

bind ini_line_parser_unit ilp_checker u_ilp_checker (.*);

`default_nettype wire

### test/ini_line_parser_unit_tb.sv
// Self-checking testbench for ini_line_parser_unit: directed table, then random INI text.
// Depends on ilp_pkg and the unit itself; results are checked against fixed table rows or an in-bench parser model.
`timescale 1ns / 1ps

module ini_line_parser_unit_tb;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam logic [1:0] SEL_NONE = 2'd3;
  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 650;

  typedef enum logic [3:0] {
    M_LINE, M_SKIP, M_SEC_LEAD, M_SEC, M_KEY, M_VAL_LEAD, M_VAL, M_AFTER_PAIR, M_ERROR, M_DONE
  } line_mode_e;

  typedef struct {
    ilp_pkg::ilp_in_t  stim;
    bit                fixed;
    ilp_pkg::ilp_out_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  ilp_pkg::ilp_in_t  in_data = '0;
  logic              in_ready;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ilp_pkg::ilp_out_t out_data;

  // parser state mirrored in the bench
  line_mode_e mode = M_LINE;
  logic [7:0] sec_mem [ilp_pkg::SectionCharsDef];
  logic [7:0] key_mem [ilp_pkg::KeyCharsDef];
  logic [7:0] val_mem [ilp_pkg::ValueCharsDef];
  bit         sec_seen [ilp_pkg::SectionCharsDef];
  bit         key_seen [ilp_pkg::KeyCharsDef];
  bit         val_seen [ilp_pkg::ValueCharsDef];
  int         sec_cnt = 0;
  int         key_cnt = 0;
  int         key_trim = 0;
  int         val_cnt = 0;
  int         val_trim = 0;

  ilp_pkg::ilp_out_t owed_results [$];
  ilp_pkg::ilp_out_t head_result;
  dir_row_t          dir_tab [$];
  int                items_sent = 0;
  int                results_seen = 0;
  int                fail_count = 0;
  int                cycle_count;

  ini_line_parser_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------- parser model ----------------

  function automatic bit blank_char(logic [7:0] b);
    return b == ilp_pkg::CH_SPACE || b == ilp_pkg::CH_TAB || b == ilp_pkg::CH_CR;
  endfunction

  function automatic void drop_pair();
    key_cnt = 0;
    key_trim = 0;
    val_cnt = 0;
    val_trim = 0;
  endfunction

  function automatic void sec_add(logic [7:0] b);
    if (sec_cnt >= ilp_pkg::SectionCharsDef) return;
    sec_mem[sec_cnt] = blank_char(b) ? ilp_pkg::CH_SPACE : b;
    sec_seen[sec_cnt] = 1'b1;
    sec_cnt++;
  endfunction

  function automatic void key_add(logic [7:0] b);
    logic [7:0] c;
    if (key_cnt >= ilp_pkg::KeyCharsDef) return;
    c = blank_char(b) ? ilp_pkg::CH_SPACE : b;
    key_mem[key_cnt] = c;
    key_seen[key_cnt] = 1'b1;
    key_cnt++;
    if (c != ilp_pkg::CH_SPACE) key_trim = key_cnt;
  endfunction

  function automatic void val_add(logic [7:0] b);
    if (val_cnt >= ilp_pkg::ValueCharsDef) return;
    val_mem[val_cnt] = b;
    val_seen[val_cnt] = 1'b1;
    val_cnt++;
    if (!blank_char(b)) val_trim = val_cnt;
  endfunction

  function automatic logic [1:0] take_byte(logic [7:0] b);
    if (mode == M_AFTER_PAIR) begin
      drop_pair();
      mode = M_LINE;
    end
    case (mode)
      M_LINE: begin
        if (blank_char(b) || b == ilp_pkg::CH_LF) return ilp_pkg::EV_NONE;
        if (b == ilp_pkg::CH_HASH || b == ilp_pkg::CH_SEMI) begin
          mode = M_SKIP;
        end else if (b == ilp_pkg::CH_LBRK) begin
          drop_pair();
          sec_cnt = 0;
          mode = M_SEC_LEAD;
        end else if (b == ilp_pkg::CH_EQ) begin
          mode = M_ERROR;
          return ilp_pkg::EV_ERROR;
        end else begin
          key_cnt = 0;
          key_trim = 0;
          mode = M_KEY;
          key_add(b);
        end
        return ilp_pkg::EV_NONE;
      end
      M_SKIP: begin
        if (b == ilp_pkg::CH_LF) mode = M_LINE;
        return ilp_pkg::EV_NONE;
      end
      M_SEC_LEAD, M_SEC: begin
        if (b == ilp_pkg::CH_LF) begin
          mode = M_LINE;
        end else if (b == ilp_pkg::CH_RBRK) begin
          mode = M_SKIP;
        end else if (!(mode == M_SEC_LEAD && blank_char(b))) begin
          mode = M_SEC;
          sec_add(b);
        end
        return ilp_pkg::EV_NONE;
      end
      M_KEY: begin
        if (b == ilp_pkg::CH_LF) begin
          mode = M_ERROR;
          return ilp_pkg::EV_ERROR;
        end
        if (b == ilp_pkg::CH_EQ) begin
          if (key_trim == 0) begin
            mode = M_ERROR;
            return ilp_pkg::EV_ERROR;
          end
          mode = M_VAL_LEAD;
          return ilp_pkg::EV_NONE;
        end
        key_add(b);
        return ilp_pkg::EV_NONE;
      end
      M_VAL_LEAD, M_VAL: begin
        if (b == ilp_pkg::CH_LF) begin
          mode = M_AFTER_PAIR;
          return ilp_pkg::EV_PAIR;
        end
        if (mode == M_VAL_LEAD && blank_char(b)) return ilp_pkg::EV_NONE;
        mode = M_VAL;
        val_add(b);
        return ilp_pkg::EV_NONE;
      end
      default: return ilp_pkg::EV_NONE;
    endcase
  endfunction

  function automatic logic [1:0] close_text();
    case (mode)
      M_ERROR: return ilp_pkg::EV_ERROR;
      M_DONE:  return ilp_pkg::EV_DONE;
      M_VAL: begin
        // a value cut off by end of input keeps its trailing blanks
        val_trim = val_cnt;
        mode = M_DONE;
        return ilp_pkg::EV_PAIR;
      end
      M_AFTER_PAIR: begin
        drop_pair();
        mode = M_DONE;
        return ilp_pkg::EV_DONE;
      end
      default: begin
        mode = M_DONE;
        return ilp_pkg::EV_DONE;
      end
    endcase
  endfunction

  function automatic logic [7:0] fetch_byte(logic [1:0] s, logic [7:0] ix);
    case (s)
      ilp_pkg::SEL_SECTION: return (ix < sec_cnt) ? sec_mem[ix] : 8'h00;
      ilp_pkg::SEL_KEY:     return (ix < key_trim) ? key_mem[ix] : 8'h00;
      ilp_pkg::SEL_VALUE:   return (ix < val_trim) ? val_mem[ix] : 8'h00;
      default:              return 8'h00;
    endcase
  endfunction

  function automatic ilp_pkg::ilp_out_t parse_item(ilp_pkg::ilp_in_t it);
    ilp_pkg::ilp_out_t r;
    r = '0;
    case (it.func)
      ilp_pkg::FUNC_PUSH: begin
        if (mode != M_ERROR && mode != M_DONE) r.event_res = take_byte(it.byte_in);
      end
      ilp_pkg::FUNC_END:  r.event_res = close_text();
      ilp_pkg::FUNC_READ: r.read_byte = fetch_byte(it.store_select, it.read_index);
      default: ;
    endcase
    r.section_length = 7'(sec_cnt);
    r.key_length     = 7'(key_trim);
    r.value_length   = 9'(val_trim);
    return r;
  endfunction

  // store entries never written must not be read
  function automatic bit read_safe(logic [1:0] s, logic [7:0] ix);
    case (s)
      ilp_pkg::SEL_SECTION: return ix >= ilp_pkg::SectionCharsDef || sec_seen[ix];
      ilp_pkg::SEL_KEY:     return ix >= ilp_pkg::KeyCharsDef || key_seen[ix];
      ilp_pkg::SEL_VALUE:   return val_seen[ix];
      default:              return 1'b1;
    endcase
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic ilp_pkg::ilp_in_t make_item(logic [1:0] f, logic [7:0] b,
                                                 logic [1:0] s, logic [7:0] ix);
    ilp_pkg::ilp_in_t it;
    it.func = f;
    it.byte_in = b;
    it.store_select = s;
    it.read_index = ix;
    return it;
  endfunction

  function automatic dir_row_t row(logic [1:0] f, logic [7:0] b, logic [1:0] s, logic [7:0] ix,
                                   bit fx, logic [1:0] ev, logic [7:0] rb, logic [6:0] sl,
                                   logic [6:0] kl, logic [8:0] vl);
    dir_row_t r;
    r.stim = make_item(f, b, s, ix);
    r.fixed = fx;
    r.want.event_res = ev;
    r.want.read_byte = rb;
    r.want.section_length = sl;
    r.want.key_length = kl;
    r.want.value_length = vl;
    return r;
  endfunction

  function automatic logic [7:0] blank_pick();
    case ($urandom_range(0, 2))
      0:       return ilp_pkg::CH_SPACE;
      1:       return ilp_pkg::CH_TAB;
      default: return ilp_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ilp_pkg::CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] key_head();
    logic [7:0] b;
    do b = 8'($urandom);
    while (blank_char(b) || b == ilp_pkg::CH_LF || b == ilp_pkg::CH_HASH ||
           b == ilp_pkg::CH_SEMI || b == ilp_pkg::CH_LBRK || b == ilp_pkg::CH_EQ);
    return b;
  endfunction

  function automatic logic [7:0] key_body();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ilp_pkg::CH_LF || b == ilp_pkg::CH_EQ);
    return b;
  endfunction

  function automatic logic [7:0] sec_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ilp_pkg::CH_LF || b == ilp_pkg::CH_RBRK);
    return b;
  endfunction

  // one transfer; starts at a falling edge, returns after the accepting rising edge
  task automatic send_item(ilp_pkg::ilp_in_t it, bit fixed, ilp_pkg::ilp_out_t want);
    ilp_pkg::ilp_out_t pred;
    @(negedge clk);
    while ((items_sent < 400 || items_sent >= 520) && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = parse_item(it);
    owed_results.push_back(fixed ? want : pred);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(make_item(ilp_pkg::FUNC_PUSH, b, 2'($urandom), 8'($urandom)), 1'b0, '0);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic issue_read();
    logic [1:0] s;
    logic [7:0] ix;
    int span;
    s = 2'($urandom_range(0, 3));
    span = (s == ilp_pkg::SEL_SECTION) ? sec_cnt : (s == ilp_pkg::SEL_KEY) ? key_trim :
           (s == ilp_pkg::SEL_VALUE) ? val_trim : 0;
    if (span > 0 && $urandom_range(0, 9) < 7) ix = 8'($urandom_range(0, span - 1));
    else ix = 8'($urandom);
    if (!read_safe(s, ix)) s = SEL_NONE;
    send_item(make_item(ilp_pkg::FUNC_READ, 8'($urandom), s, ix), 1'b0, '0);
  endtask

  task automatic put_section(int n);
    send_byte(ilp_pkg::CH_LBRK);
    repeat ($urandom_range(0, 1)) send_byte(blank_pick());
    repeat (n) send_byte(sec_byte());
    if ($urandom_range(0, 9) < 7) begin
      send_byte(ilp_pkg::CH_RBRK);
      repeat ($urandom_range(0, 2)) send_byte(line_byte());
    end
    send_byte(ilp_pkg::CH_LF);
    repeat ($urandom_range(0, 2)) issue_read();
  endtask

  task automatic put_pair(int klen, int vlen);
    repeat ($urandom_range(0, 2)) send_byte(blank_pick());
    send_byte(key_head());
    repeat (klen - 1) send_byte(($urandom_range(0, 4) == 0) ? blank_pick() : key_body());
    repeat ($urandom_range(0, 2)) send_byte(blank_pick());
    send_byte(ilp_pkg::CH_EQ);
    repeat ($urandom_range(0, 2)) send_byte(blank_pick());
    repeat (vlen) send_byte(line_byte());
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) send_byte(blank_pick());
    send_byte(ilp_pkg::CH_LF);
    repeat ($urandom_range(0, 4)) issue_read();
  endtask

  // ---------------- result checking ----------------

  always @(negedge clk) begin
    out_ready <= (results_seen >= 400 && results_seen < 520) || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result with nothing outstanding: %p", out_data);
      end else begin
        head_result = owed_results.pop_front();
        if (out_data.event_res !== head_result.event_res ||
            out_data.read_byte !== head_result.read_byte ||
            out_data.section_length !== head_result.section_length ||
            out_data.key_length !== head_result.key_length ||
            out_data.value_length !== head_result.value_length) begin
          fail_count++;
          if (fail_count <= 10) begin
            $write("result %0d mismatch: exp ev %0d byte %02h sec %0d key %0d val %0d,",
                   results_seen, head_result.event_res, head_result.read_byte,
                   head_result.section_length, head_result.key_length,
                   head_result.value_length);
            $display(" got ev %0d byte %02h sec %0d key %0d val %0d",
                     out_data.event_res, out_data.read_byte, out_data.section_length,
                     out_data.key_length, out_data.value_length);
          end
        end
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // ---------------- main sequence ----------------

  initial begin
    int base;
    int pick;
    bit long_done;
    long_done = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // row(func, byte, sel, idx, fixed, ev, read byte, section len, key len, value len)
    dir_tab.push_back(row(ilp_pkg::FUNC_READ, 8'h00, ilp_pkg::SEL_SECTION, 8'hff,
                          1, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(FUNC_NOP, 8'hff, SEL_NONE, 8'hff,
                          1, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_READ, 8'h00, SEL_NONE, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_SPACE, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_HASH, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, 8'hff, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_LF, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_LBRK, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_TAB, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, 8'h00, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 1, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_CR, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 2, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, 8'hff, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_RBRK, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, "z", ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_LF, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_READ, 8'h00, ilp_pkg::SEL_SECTION, 8'h01,
                          1, ilp_pkg::EV_NONE, 8'h20, 3, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_SEMI, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_LF, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, "k", ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 1, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_TAB, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 1, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_EQ, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 1, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_SPACE, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 1, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_LF, ilp_pkg::SEL_SECTION, 8'h00,
                          1, ilp_pkg::EV_PAIR, 8'h00, 3, 1, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_READ, 8'h00, ilp_pkg::SEL_KEY, 8'h00,
                          1, ilp_pkg::EV_NONE, "k", 3, 1, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_READ, 8'h00, ilp_pkg::SEL_KEY, 8'h01,
                          1, ilp_pkg::EV_NONE, 8'h00, 3, 1, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, "v", ilp_pkg::SEL_SECTION, 8'h00,
                          0, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_EQ, ilp_pkg::SEL_SECTION, 8'h00,
                          0, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, 8'hfe, ilp_pkg::SEL_SECTION, 8'h00,
                          0, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_PUSH, ilp_pkg::CH_LF, ilp_pkg::SEL_SECTION, 8'h00,
                          0, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));
    dir_tab.push_back(row(ilp_pkg::FUNC_READ, 8'h00, ilp_pkg::SEL_VALUE, 8'h00,
                          0, ilp_pkg::EV_NONE, 8'h00, 0, 0, 0));

    foreach (dir_tab[i]) send_item(dir_tab[i].stim, dir_tab[i].fixed, dir_tab[i].want);

    // random well-formed text; every line is closed so the parser stays live
    base = items_sent;
    while (items_sent < base + RandomItems) begin
      if (!long_done && items_sent >= base + 250) begin
        // let the pipe run dry, then overflow every store once
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge clk);
        put_section(ilp_pkg::SectionCharsDef + 2);
        put_pair(ilp_pkg::KeyCharsDef + 2, ilp_pkg::ValueCharsDef + 2);
        long_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(0, 3)) send_byte(blank_pick());
        send_byte(ilp_pkg::CH_LF);
      end else if (pick < 20) begin
        repeat ($urandom_range(0, 1)) send_byte(blank_pick());
        send_byte($urandom_range(0, 1) ? ilp_pkg::CH_HASH : ilp_pkg::CH_SEMI);
        repeat ($urandom_range(0, 8)) send_byte(line_byte());
        send_byte(ilp_pkg::CH_LF);
      end else if (pick < 35) begin
        put_section($urandom_range(0, 10));
      end else if (pick < 90) begin
        put_pair($urandom_range(1, 8), $urandom_range(0, 12));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 3) == 0)
            send_item(make_item(FUNC_NOP, 8'($urandom), 2'($urandom), 8'($urandom)), 1'b0, '0);
          else
            issue_read();
        end
      end
    end

    // one terminal ending per run, then check the parser stays stuck
    case ($urandom_range(0, 6))
      0:       send_text("=");
      1:       send_text("ab\n");
      2:       send_text("k= v \t");
      3:       send_text("k =");
      4:       send_text("k");
      5:       ;
      default: send_text("[s");
    endcase
    send_item(make_item(ilp_pkg::FUNC_END, 8'($urandom), 2'($urandom), 8'($urandom)),
              1'b0, '0);
    repeat (8) begin
      pick = $urandom_range(0, 3);
      if (pick == 3) issue_read();
      else
        send_item(make_item((pick == 2) ? FUNC_NOP : 2'(pick), 8'($urandom), 2'($urandom),
                            8'($urandom)), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
